>>> design/h264_sps_size_parser_unit_defines.svh
// Assertion macros for the sequence parameter set size parser.
// Included by the RTL files that carry assertions; depends on nothing.
`ifndef H264_SPS_SIZE_PARSER_UNIT_DEFINES_SVH
`define H264_SPS_SIZE_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SPS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> design/sps_pkg.sv
// Package for the sequence parameter set size parser: syntax steps,
// status codes, command and status structs. Depends on nothing.
`default_nettype none
package sps_pkg;
    localparam int MaxLeadingZeros = 31;
    localparam int DimBits = 16;
    localparam logic [15:0] DimMax = (DimBits >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << DimBits) - 32'd1);

    typedef enum logic [5:0] {
        ST_HDR, ST_PROFILE, ST_FLAGS, ST_LEVEL, ST_ID, ST_CHROMA, ST_RCT, ST_BDL,
        ST_BDC, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_SCALE, ST_LOG2FN, ST_POCTYPE,
        ST_LOG2POC, ST_DZERO, ST_OFFNR, ST_OFFTB, ST_NCYCLE, ST_OFFREF, ST_NREF,
        ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FRAMEONLY, ST_MBAFF, ST_DIRECT,
        ST_CROPFLAG, ST_CL, ST_CR, ST_CT, ST_CB, ST_DONE
    } step_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EARLY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Fixed bit count of each step; zero marks an Exp-Golomb code.
    function automatic logic [3:0] step_bits(input step_t s);
        logic [3:0] r;
        begin
            case (s)
                ST_HDR, ST_PROFILE, ST_FLAGS, ST_LEVEL: r = 4'd8;
                ST_RCT, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DZERO, ST_GAPS,
                ST_FRAMEONLY, ST_MBAFF, ST_DIRECT, ST_CROPFLAG: r = 4'd1;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic load;   // take a new byte into the shifter
        logic shift;  // consume one bit
        logic finish; // clear the parser state for the next unit
    } cmd_t;

    typedef struct packed {
        logic busy;      // bits still to consume
        logic final_bit; // the next bit is the last one of the byte
        logic last_pend; // the byte being consumed is the last one
    } stat_t;

    typedef enum logic [2:0] {
        CT_IDLE = 3'b001,
        CT_BITS = 3'b010,
        CT_OUT  = 3'b100
    } ctrl_state_t;
endpackage
`default_nettype wire

>>> design/h264_sps_size_parser_unit.sv
// Sequence parameter set size parser, top level: streaming ports, result
// register, controller and datapath. Depends on sps_pkg, sps_ctrl, sps_datapath.
// Bytes are taken one at a time: a byte is loaded, then its eight bits are consumed
// before the next byte is accepted. A last byte's result is then handed off;
// while the result register is still full, the handoff and input wait.
// Reset (aresetn low, synchronous) returns to the header byte, clears m_tvalid.
`default_nettype none
module h264_sps_size_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pic_width, pic_height, profile_code, level_code, set_id, frames_only,
    // parse_status, from the lowest bit up
    output logic [55:0]      m_tdata
);
    sps_pkg::cmd_t  cmd;
    sps_pkg::stat_t stat;
    logic capture;
    logic [15:0] w, h;
    logic [7:0] prof, lev;
    logic [4:0] sid;
    logic fo;
    logic [1:0] st;
    logic [55:0] res_reg;

    // The controller accepts a byte, runs the bit loop for its eight bits and,
    // after the last bit of a last byte, moves on to the result handoff.
    // The handoff waits while the output register still holds an unsent result.
    sps_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd),
        .capture(capture)
    );

    sps_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_byte(s_tdata), .in_last(s_tlast), .res_width(w), .res_height(h),
        .res_profile(prof), .res_level(lev), .res_id(sid), .res_frames(fo),
        .res_status(st)
    );

    // The result is taken from the final parser state in the same cycle in
    // which the datapath is told to clear it for the next unit.
    always_ff @(posedge aclk) begin
        if (capture) res_reg <= {st, fo, sid, lev, prof, h, w};
    end
    assign m_tdata = res_reg;
endmodule
`default_nettype wire

>>> design/sps_datapath.sv
// Datapath of the sequence parameter set size parser: bit shifter, syntax
// walker and the size computation. Depends on sps_pkg.
`default_nettype none
`include "h264_sps_size_parser_unit_defines.svh"
module sps_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire sps_pkg::cmd_t  cmd,
    output sps_pkg::stat_t      stat,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    output logic [15:0]         res_width,
    output logic [15:0]         res_height,
    output logic [7:0]          res_profile,
    output logic [7:0]          res_level,
    output logic [4:0]          res_id,
    output logic                res_frames,
    output logic [1:0]          res_status
);
    logic [7:0]  byte_reg, byte_next;
    logic [3:0]  bits_reg, bits_next;
    logic        lastp_reg, lastp_next;
    sps_pkg::step_t step_reg, step_next;
    logic [4:0]  lzc_reg, lzc_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  suf_reg, suf_next;
    logic [3:0]  fix_reg, fix_next;
    logic [7:0]  prof_reg, prof_next, lev_reg, lev_next;
    logic [4:0]  id_reg, id_next;
    logic [1:0]  poc_reg, poc_next;
    logic [3:0]  lidx_reg, lidx_next;
    logic [7:0]  cnt_reg, cnt_next, last_reg, last_next, nsc_reg, nsc_next;
    logic [15:0] wmb_reg, wmb_next, hmu_reg, hmu_next;
    logic        fo_reg, fo_next;
    logic [16:0] ch_reg, ch_next, cv_reg, cv_next;
    logic        done_reg, done_next, err_reg, err_next;

    logic        bit_in, fin;
    logic [31:0] fv;
    logic [31:0] acc_sh;
    logic [31:0] acc_dec;
    logic [4:0]  lzc_dec, suf_dec;
    logic [3:0]  fix_dec;
    logic        err_dec;
    sps_pkg::step_t tgt;
    logic        tgt_en;
    logic [7:0]  delta, nx;
    logic [3:0]  lidx_inc;
    logic [17:0] csum;
    logic [7:0]  cnt_dec;

    assign bit_in = byte_reg[7];
    assign acc_sh = {acc_reg[30:0], bit_in};
    assign stat.busy = (bits_reg != 4'd0);
    assign stat.final_bit = (bits_reg == 4'd1);
    assign stat.last_pend = lastp_reg;

    // Bit-level decode: decides whether this bit ends a syntax element.
    always_comb begin
        fin = 1'b0;
        fv = 32'd0;
        acc_dec = acc_reg;
        lzc_dec = lzc_reg;
        suf_dec = suf_reg;
        fix_dec = fix_reg;
        err_dec = err_reg;
        if (step_reg != sps_pkg::ST_DONE) begin
            if (sps_pkg::step_bits(step_reg) != 4'd0) begin
                acc_dec = acc_sh;
                if (fix_reg != 4'd0) fix_dec = fix_reg - 4'd1;
                if (fix_reg <= 4'd1) begin
                    fin = 1'b1;
                    fv = acc_sh;
                end
            end else if (suf_reg != 5'd0) begin
                acc_dec = acc_sh;
                suf_dec = suf_reg - 5'd1;
                if (suf_reg == 5'd1) begin
                    fin = 1'b1;
                    fv = acc_sh - 32'd1;
                end
            end else if (bit_in) begin
                if (lzc_reg == 5'd0) begin
                    fin = 1'b1;
                end else begin
                    acc_dec = 32'd1;
                    suf_dec = lzc_reg;
                end
            end else if (32'(lzc_reg) >= sps_pkg::MaxLeadingZeros) begin
                err_dec = 1'b1;
                fin = 1'b1;
            end else begin
                lzc_dec = lzc_reg + 5'd1;
            end
        end
    end

    assign lidx_inc = lidx_reg + 4'd1;
    assign delta = fv[0] ? fv[8:1] + {7'd0, fv[0]} : 8'd0 - fv[8:1];
    assign nx = last_reg + delta;
    assign cnt_dec = cnt_reg - 8'd1;
    assign csum = {1'b0, (step_reg == sps_pkg::ST_CL || step_reg == sps_pkg::ST_CR)
                  ? ch_reg : cv_reg} + {1'b0, fv[16:0]};

    // Syntax walker: what a finished element does to the state.
    always_comb begin
        tgt = step_reg;
        tgt_en = 1'b0;
        err_next = err_dec;
        prof_next = prof_reg; lev_next = lev_reg; id_next = id_reg;
        poc_next = poc_reg; lidx_next = lidx_reg; cnt_next = cnt_reg;
        last_next = last_reg; nsc_next = nsc_reg; wmb_next = wmb_reg;
        hmu_next = hmu_reg; fo_next = fo_reg; ch_next = ch_reg; cv_next = cv_reg;
        done_next = done_reg;
        if (fin) begin
            tgt_en = 1'b1;
            case (step_reg)
                sps_pkg::ST_HDR: tgt = sps_pkg::ST_PROFILE;
                sps_pkg::ST_PROFILE: begin
                    prof_next = fv[7:0];
                    tgt = sps_pkg::ST_FLAGS;
                end
                sps_pkg::ST_FLAGS: tgt = sps_pkg::ST_LEVEL;
                sps_pkg::ST_LEVEL: begin
                    lev_next = fv[7:0];
                    tgt = sps_pkg::ST_ID;
                end
                sps_pkg::ST_ID: begin
                    id_next = (fv > 32'd31) ? 5'd31 : fv[4:0];
                    tgt = (prof_reg inside {8'd100, 8'd110, 8'd122, 8'd144})
                          ? sps_pkg::ST_CHROMA : sps_pkg::ST_LOG2FN;
                end
                sps_pkg::ST_CHROMA:
                    tgt = (fv == 32'd3) ? sps_pkg::ST_RCT : sps_pkg::ST_BDL;
                sps_pkg::ST_RCT: tgt = sps_pkg::ST_BDL;
                sps_pkg::ST_BDL: tgt = sps_pkg::ST_BDC;
                sps_pkg::ST_BDC: tgt = sps_pkg::ST_BYPASS;
                sps_pkg::ST_BYPASS: tgt = sps_pkg::ST_MATRIX;
                sps_pkg::ST_MATRIX: begin
                    lidx_next = 4'd0;
                    tgt = fv[0] ? sps_pkg::ST_LISTFLAG : sps_pkg::ST_LOG2FN;
                end
                sps_pkg::ST_LISTFLAG: begin
                    if (fv[0]) begin
                        cnt_next = (lidx_reg < 4'd6) ? 8'd16 : 8'd64;
                        last_next = 8'd8;
                        nsc_next = 8'd8;
                        tgt = sps_pkg::ST_SCALE;
                    end else begin
                        lidx_next = lidx_inc;
                        tgt = (lidx_inc >= 4'd8) ? sps_pkg::ST_LOG2FN
                                                 : sps_pkg::ST_LISTFLAG;
                    end
                end
                sps_pkg::ST_SCALE: begin
                    nsc_next = nx;
                    if (nx != 8'd0) last_next = nx;
                    cnt_next = cnt_dec;
                    if (cnt_dec == 8'd0 || nx == 8'd0) begin
                        lidx_next = lidx_inc;
                        tgt = (lidx_inc >= 4'd8) ? sps_pkg::ST_LOG2FN
                                                 : sps_pkg::ST_LISTFLAG;
                    end else begin
                        tgt = sps_pkg::ST_SCALE;
                    end
                end
                sps_pkg::ST_LOG2FN: tgt = sps_pkg::ST_POCTYPE;
                sps_pkg::ST_POCTYPE: begin
                    poc_next = (fv > 32'd3) ? 2'd3 : fv[1:0];
                    tgt = (poc_next == 2'd0) ? sps_pkg::ST_LOG2POC
                        : (poc_next == 2'd1) ? sps_pkg::ST_DZERO : sps_pkg::ST_NREF;
                end
                sps_pkg::ST_LOG2POC: tgt = sps_pkg::ST_NREF;
                sps_pkg::ST_DZERO: tgt = sps_pkg::ST_OFFNR;
                sps_pkg::ST_OFFNR: tgt = sps_pkg::ST_OFFTB;
                sps_pkg::ST_OFFTB: tgt = sps_pkg::ST_NCYCLE;
                sps_pkg::ST_NCYCLE: begin
                    if (fv > 32'd255) begin
                        cnt_next = 8'd255;
                        err_next = 1'b1;
                    end else begin
                        cnt_next = fv[7:0];
                    end
                    tgt = (fv == 32'd0) ? sps_pkg::ST_NREF : sps_pkg::ST_OFFREF;
                end
                sps_pkg::ST_OFFREF: begin
                    cnt_next = cnt_dec;
                    tgt = (cnt_dec == 8'd0) ? sps_pkg::ST_NREF : sps_pkg::ST_OFFREF;
                end
                sps_pkg::ST_NREF: tgt = sps_pkg::ST_GAPS;
                sps_pkg::ST_GAPS: tgt = sps_pkg::ST_WIDTH;
                sps_pkg::ST_WIDTH: begin
                    wmb_next = (fv >= 32'hFFFF) ? 16'hFFFF : fv[15:0] + 16'd1;
                    tgt = sps_pkg::ST_HEIGHT;
                end
                sps_pkg::ST_HEIGHT: begin
                    hmu_next = (fv >= 32'hFFFF) ? 16'hFFFF : fv[15:0] + 16'd1;
                    tgt = sps_pkg::ST_FRAMEONLY;
                end
                sps_pkg::ST_FRAMEONLY: begin
                    fo_next = fv[0];
                    tgt = fv[0] ? sps_pkg::ST_DIRECT : sps_pkg::ST_MBAFF;
                end
                sps_pkg::ST_MBAFF: tgt = sps_pkg::ST_DIRECT;
                sps_pkg::ST_DIRECT: tgt = sps_pkg::ST_CROPFLAG;
                sps_pkg::ST_CROPFLAG: begin
                    if (fv[0]) begin
                        tgt = sps_pkg::ST_CL;
                    end else begin
                        done_next = 1'b1;
                        tgt = sps_pkg::ST_DONE;
                    end
                end
                sps_pkg::ST_CL, sps_pkg::ST_CR: begin
                    ch_next = (fv > 32'h1FFFF || csum[17]) ? 17'h1FFFF : csum[16:0];
                    tgt = (step_reg == sps_pkg::ST_CL) ? sps_pkg::ST_CR
                                                       : sps_pkg::ST_CT;
                end
                sps_pkg::ST_CT: begin
                    cv_next = (fv > 32'h1FFFF || csum[17]) ? 17'h1FFFF : csum[16:0];
                    tgt = sps_pkg::ST_CB;
                end
                sps_pkg::ST_CB: begin
                    cv_next = (fv > 32'h1FFFF || csum[17]) ? 17'h1FFFF : csum[16:0];
                    done_next = 1'b1;
                    tgt = sps_pkg::ST_DONE;
                end
                default: tgt = sps_pkg::ST_DONE;
            endcase
        end
    end

    always_comb begin
        step_next = step_reg;
        fix_next = fix_dec;
        lzc_next = lzc_dec;
        acc_next = acc_dec;
        suf_next = suf_dec;
        if (tgt_en) begin
            step_next = tgt;
            fix_next = sps_pkg::step_bits(tgt);
            lzc_next = 5'd0;
            acc_next = 32'd0;
            suf_next = 5'd0;
        end
    end

    // Size computation on the final state; runs in the output cycle.
    logic [20:0] full_w, crop_w;
    logic [21:0] full_h, crop_h;
    logic [21:0] diff_w, diff_h;
    logic        e_w, e_h;
    always_comb begin
        full_w = {1'b0, wmb_reg, 4'd0};
        crop_w = {3'd0, ch_reg, 1'b0};
        full_h = fo_reg ? {2'd0, hmu_reg, 4'd0} : {1'd0, hmu_reg, 5'd0};
        crop_h = fo_reg ? {4'd0, cv_reg, 1'b0} : {3'd0, cv_reg, 2'b0};
        diff_w = {1'b0, full_w} - {1'b0, crop_w};
        diff_h = full_h - crop_h;
        e_w = 1'b0;
        e_h = 1'b0;
        res_width = 16'd0;
        res_height = 16'd0;
        if (done_reg) begin
            if ({1'b0, crop_w} > {1'b0, full_w}) begin
                e_w = 1'b1;
            end else if (diff_w > {6'd0, sps_pkg::DimMax}) begin
                e_w = 1'b1;
                res_width = sps_pkg::DimMax;
            end else begin
                res_width = diff_w[15:0];
            end
            if (crop_h > full_h) begin
                e_h = 1'b1;
            end else if (diff_h > {6'd0, sps_pkg::DimMax}) begin
                e_h = 1'b1;
                res_height = sps_pkg::DimMax;
            end else begin
                res_height = diff_h[15:0];
            end
        end
        res_status = !done_reg ? sps_pkg::STATUS_EARLY
                   : (err_reg || e_w || e_h) ? sps_pkg::STATUS_RANGE
                   : sps_pkg::STATUS_OK;
    end
    assign res_profile = prof_reg;
    assign res_level = lev_reg;
    assign res_id = id_reg;
    assign res_frames = fo_reg;

    always_comb begin
        byte_next = byte_reg;
        bits_next = bits_reg;
        lastp_next = lastp_reg;
        if (cmd.load) begin
            byte_next = in_byte;
            bits_next = 4'd8;
            lastp_next = in_last;
        end else if (cmd.shift) begin
            byte_next = {byte_reg[6:0], 1'b0};
            bits_next = bits_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (!aresetn) begin
            bits_reg <= 4'd0;
            lastp_reg <= 1'b0;
        end else begin
            bits_reg <= bits_next;
            lastp_reg <= lastp_next;
        end
        if (!aresetn || cmd.finish) begin
            step_reg <= sps_pkg::ST_HDR;
            fix_reg <= 4'd8;
            lzc_reg <= 5'd0; acc_reg <= 32'd0; suf_reg <= 5'd0;
            prof_reg <= 8'd0; lev_reg <= 8'd0; id_reg <= 5'd0; poc_reg <= 2'd0;
            lidx_reg <= 4'd0; cnt_reg <= 8'd0; last_reg <= 8'd8; nsc_reg <= 8'd8;
            wmb_reg <= 16'd0; hmu_reg <= 16'd0; fo_reg <= 1'b0;
            ch_reg <= 17'd0; cv_reg <= 17'd0; done_reg <= 1'b0; err_reg <= 1'b0;
        end else if (cmd.shift) begin
            step_reg <= step_next; fix_reg <= fix_next; lzc_reg <= lzc_next;
            acc_reg <= acc_next; suf_reg <= suf_next;
            prof_reg <= prof_next; lev_reg <= lev_next; id_reg <= id_next;
            poc_reg <= poc_next; lidx_reg <= lidx_next; cnt_reg <= cnt_next;
            last_reg <= last_next; nsc_reg <= nsc_next; wmb_reg <= wmb_next;
            hmu_reg <= hmu_next; fo_reg <= fo_next; ch_reg <= ch_next;
            cv_reg <= cv_next; done_reg <= done_next; err_reg <= err_next;
        end
    end

    `SPS_ASSERT_IMPL(a_done_step, aclk, aresetn, done_reg, step_reg == sps_pkg::ST_DONE)
    `SPS_ASSERT_IMPL(a_no_load_busy, aclk, aresetn, stat.busy, !cmd.load)
    `SPS_ASSERT_NEXT(a_finish_clears, aclk, aresetn, cmd.finish,
                     step_reg == sps_pkg::ST_HDR && !done_reg && !err_reg)
endmodule
`default_nettype wire

>>> design/sps_ctrl.sv
// Controller of the sequence parameter set size parser: byte intake,
// bit sequencing and result handoff. Depends on sps_pkg.
`default_nettype none
`include "h264_sps_size_parser_unit_defines.svh"
module sps_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire sps_pkg::stat_t  stat,
    output sps_pkg::cmd_t        cmd,
    output logic                 capture
);
    sps_pkg::ctrl_state_t state_reg, state_next;
    logic ov_reg, ov_next;

    always_comb begin
        state_next = state_reg;
        ov_next = ov_reg;
        cmd = '0;
        capture = 1'b0;
        in_ready = 1'b0;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            sps_pkg::CT_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = sps_pkg::CT_BITS;
                end
            end
            sps_pkg::CT_BITS: begin
                cmd.shift = 1'b1;
                // Leave the bit loop with the eighth bit of the byte.
                if (stat.final_bit) begin
                    state_next = stat.last_pend ? sps_pkg::CT_OUT : sps_pkg::CT_IDLE;
                end
            end
            sps_pkg::CT_OUT: begin
                if (!ov_reg || out_ready) begin
                    capture = 1'b1;
                    cmd.finish = 1'b1;
                    ov_next = 1'b1;
                    state_next = sps_pkg::CT_IDLE;
                end
            end
            default: state_next = sps_pkg::CT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sps_pkg::CT_IDLE;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
    assign out_valid = ov_reg;

    `SPS_ASSERT_IMPL(a_load_idle, aclk, aresetn, cmd.load,
                     state_reg == sps_pkg::CT_IDLE)
    `SPS_ASSERT_IMPL(a_capture_free, aclk, aresetn, capture, !ov_reg || out_ready)
    `SPS_ASSERT_IMPL(a_state_onehot, aclk, aresetn, 1'b1, $onehot(state_reg))
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for h264_sps_size_parser_unit: builds parameter set
// units bit by bit, predicts the cropped size and status of each, and checks
// every result transfer. Depends on sps_pkg and the parser RTL.
`timescale 1ns / 1ps
module tb_top;
    typedef struct {
        logic [7:0] data;
        logic       last;
    } unit_byte_t;

    typedef struct {
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  profile;
        logic [7:0]  level;
        logic [4:0]  set_id;
        logic        frames_only;
        logic [1:0]  status;
    } size_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    h264_sps_size_parser_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    unit_byte_t   pending_bytes[$];
    size_report_t expected_sizes[$];
    bit           unit_bits[$];
    int           error_count = 0;
    bit           stimulus_done = 1'b0;

    // Predictor state: a bit-serial walk of the parameter set syntax.
    sps_pkg::step_t walk_step;
    int unsigned zero_run, suffix_left, fixed_left;
    logic [31:0] code_acc;
    logic [7:0]  profile_q, level_q, list_count, prev_scale, cur_scale;
    logic [4:0]  id_q;
    logic [1:0]  order_type_q;
    logic [3:0]  list_idx;
    logic [15:0] width_mbs_q, height_units_q;
    logic        frame_only_q, sizes_ready, range_flag;
    logic [16:0] crop_horiz, crop_vert;

    // Width of each fixed-length syntax element; zero marks an Exp-Golomb code.
    function automatic int unsigned fixed_width(sps_pkg::step_t s);
        case (s)
            sps_pkg::ST_HDR, sps_pkg::ST_PROFILE, sps_pkg::ST_FLAGS,
            sps_pkg::ST_LEVEL: return 8;
            sps_pkg::ST_RCT, sps_pkg::ST_BYPASS, sps_pkg::ST_MATRIX,
            sps_pkg::ST_LISTFLAG, sps_pkg::ST_DZERO, sps_pkg::ST_GAPS,
            sps_pkg::ST_FRAMEONLY, sps_pkg::ST_MBAFF, sps_pkg::ST_DIRECT,
            sps_pkg::ST_CROPFLAG: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void goto_step(sps_pkg::step_t s);
        walk_step = s;
        fixed_left = fixed_width(s);
        zero_run = 0;
        code_acc = '0;
        suffix_left = 0;
    endfunction

    function automatic void clear_walker();
        profile_q = '0; level_q = '0; id_q = '0; order_type_q = '0;
        list_idx = '0; list_count = '0; prev_scale = 8'd8; cur_scale = 8'd8;
        width_mbs_q = '0; height_units_q = '0; frame_only_q = 1'b0;
        crop_horiz = '0; crop_vert = '0; sizes_ready = 1'b0; range_flag = 1'b0;
        goto_step(sps_pkg::ST_HDR);
    endfunction

    function automatic void advance_list();
        list_idx = list_idx + 4'd1;
        if (list_idx >= 4'd8) goto_step(sps_pkg::ST_LOG2FN);
        else goto_step(sps_pkg::ST_LISTFLAG);
    endfunction

    function automatic void element_done(logic [31:0] v);
        logic [7:0]  delta;
        logic [7:0]  nx;
        longint unsigned wide;
        case (walk_step)
            sps_pkg::ST_HDR:     goto_step(sps_pkg::ST_PROFILE);
            sps_pkg::ST_PROFILE: begin
                profile_q = v[7:0];
                goto_step(sps_pkg::ST_FLAGS);
            end
            sps_pkg::ST_FLAGS:   goto_step(sps_pkg::ST_LEVEL);
            sps_pkg::ST_LEVEL:   begin
                level_q = v[7:0];
                goto_step(sps_pkg::ST_ID);
            end
            sps_pkg::ST_ID: begin
                id_q = (v > 31) ? 5'd31 : v[4:0];
                if (profile_q == 8'd100 || profile_q == 8'd110 ||
                    profile_q == 8'd122 || profile_q == 8'd144)
                    goto_step(sps_pkg::ST_CHROMA);
                else goto_step(sps_pkg::ST_LOG2FN);
            end
            sps_pkg::ST_CHROMA:  goto_step(v == 3 ? sps_pkg::ST_RCT : sps_pkg::ST_BDL);
            sps_pkg::ST_RCT:     goto_step(sps_pkg::ST_BDL);
            sps_pkg::ST_BDL:     goto_step(sps_pkg::ST_BDC);
            sps_pkg::ST_BDC:     goto_step(sps_pkg::ST_BYPASS);
            sps_pkg::ST_BYPASS:  goto_step(sps_pkg::ST_MATRIX);
            sps_pkg::ST_MATRIX: begin
                list_idx = '0;
                goto_step(v != 0 ? sps_pkg::ST_LISTFLAG : sps_pkg::ST_LOG2FN);
            end
            sps_pkg::ST_LISTFLAG: begin
                if (v != 0) begin
                    list_count = (list_idx < 6) ? 8'd16 : 8'd64;
                    prev_scale = 8'd8;
                    cur_scale = 8'd8;
                    goto_step(sps_pkg::ST_SCALE);
                end else begin
                    advance_list();
                end
            end
            sps_pkg::ST_SCALE: begin
                wide = {32'd0, v};
                if (v[0]) delta = 8'((wide + 1) >> 1);
                else delta = 8'(32'd0 - (v >> 1));
                nx = prev_scale + delta;
                cur_scale = nx;
                if (nx != 0) prev_scale = nx;
                list_count = list_count - 8'd1;
                if (list_count == 0 || nx == 0) advance_list();
                else goto_step(sps_pkg::ST_SCALE);
            end
            sps_pkg::ST_LOG2FN: goto_step(sps_pkg::ST_POCTYPE);
            sps_pkg::ST_POCTYPE: begin
                order_type_q = (v > 3) ? 2'd3 : v[1:0];
                if (order_type_q == 0) goto_step(sps_pkg::ST_LOG2POC);
                else if (order_type_q == 1) goto_step(sps_pkg::ST_DZERO);
                else goto_step(sps_pkg::ST_NREF);
            end
            sps_pkg::ST_LOG2POC: goto_step(sps_pkg::ST_NREF);
            sps_pkg::ST_DZERO:   goto_step(sps_pkg::ST_OFFNR);
            sps_pkg::ST_OFFNR:   goto_step(sps_pkg::ST_OFFTB);
            sps_pkg::ST_OFFTB:   goto_step(sps_pkg::ST_NCYCLE);
            sps_pkg::ST_NCYCLE: begin
                if (v > 255) begin v = 255; range_flag = 1'b1; end
                list_count = v[7:0];
                goto_step(v == 0 ? sps_pkg::ST_NREF : sps_pkg::ST_OFFREF);
            end
            sps_pkg::ST_OFFREF: begin
                list_count = list_count - 8'd1;
                goto_step(list_count == 0 ? sps_pkg::ST_NREF : sps_pkg::ST_OFFREF);
            end
            sps_pkg::ST_NREF: goto_step(sps_pkg::ST_GAPS);
            sps_pkg::ST_GAPS: goto_step(sps_pkg::ST_WIDTH);
            sps_pkg::ST_WIDTH: begin
                wide = {32'd0, v} + 1;
                width_mbs_q = (wide > 65535) ? 16'hFFFF : wide[15:0];
                goto_step(sps_pkg::ST_HEIGHT);
            end
            sps_pkg::ST_HEIGHT: begin
                wide = {32'd0, v} + 1;
                height_units_q = (wide > 65535) ? 16'hFFFF : wide[15:0];
                goto_step(sps_pkg::ST_FRAMEONLY);
            end
            sps_pkg::ST_FRAMEONLY: begin
                frame_only_q = v[0];
                goto_step(frame_only_q ? sps_pkg::ST_DIRECT : sps_pkg::ST_MBAFF);
            end
            sps_pkg::ST_MBAFF:  goto_step(sps_pkg::ST_DIRECT);
            sps_pkg::ST_DIRECT: goto_step(sps_pkg::ST_CROPFLAG);
            sps_pkg::ST_CROPFLAG: begin
                if (v != 0) goto_step(sps_pkg::ST_CL);
                else begin sizes_ready = 1'b1; goto_step(sps_pkg::ST_DONE); end
            end
            sps_pkg::ST_CL, sps_pkg::ST_CR: begin
                wide = {47'd0, crop_horiz} + v;
                crop_horiz = (wide > 17'h1FFFF) ? 17'h1FFFF : wide[16:0];
                goto_step(sps_pkg::step_t'(walk_step + 1));
            end
            sps_pkg::ST_CT, sps_pkg::ST_CB: begin
                wide = {47'd0, crop_vert} + v;
                crop_vert = (wide > 17'h1FFFF) ? 17'h1FFFF : wide[16:0];
                if (walk_step == sps_pkg::ST_CB) begin
                    sizes_ready = 1'b1;
                    goto_step(sps_pkg::ST_DONE);
                end
                else goto_step(sps_pkg::ST_CB);
            end
            default: goto_step(sps_pkg::ST_DONE);
        endcase
    endfunction

    function automatic void consume_bit(bit b);
        if (walk_step == sps_pkg::ST_DONE) return;
        if (fixed_width(walk_step) != 0) begin
            code_acc = {code_acc[30:0], b};
            if (fixed_left > 0) fixed_left--;
            if (fixed_left == 0) element_done(code_acc);
        end else if (suffix_left > 0) begin
            code_acc = {code_acc[30:0], b};
            suffix_left--;
            if (suffix_left == 0) element_done(code_acc - 32'd1);
        end else if (b) begin
            if (zero_run == 0) element_done(32'd0);
            else begin code_acc = 32'd1; suffix_left = zero_run; end
        end else if (zero_run >= sps_pkg::MaxLeadingZeros) begin
            // An overlong code ends with value zero and flags a range error.
            range_flag = 1'b1;
            element_done(32'd0);
        end else begin
            zero_run++;
        end
    endfunction

    function automatic logic [15:0] crop_dimension(longint unsigned full,
                                                   longint unsigned crop, ref bit err);
        if (crop > full) begin err = 1'b1; return 16'd0; end
        full -= crop;
        if (full > sps_pkg::DimMax) begin err = 1'b1; return sps_pkg::DimMax; end
        return full[15:0];
    endfunction

    // Feeds one accepted byte through the walker; a last byte yields one report.
    function automatic void predict_byte(unit_byte_t ub);
        size_report_t r;
        bit err;
        for (int i = 7; i >= 0; i--) consume_bit(ub.data[i]);
        if (!ub.last) return;
        err = range_flag;
        r.width = '0;
        r.height = '0;
        if (!sizes_ready) begin
            r.status = sps_pkg::STATUS_EARLY;
        end else begin
            r.width = crop_dimension(longint'(width_mbs_q) * 16,
                                     2 * longint'(crop_horiz), err);
            r.height = crop_dimension(longint'(height_units_q) * 16 * (frame_only_q ? 1 : 2),
                                      (frame_only_q ? 2 : 4) * longint'(crop_vert), err);
            r.status = err ? sps_pkg::STATUS_RANGE : sps_pkg::STATUS_OK;
        end
        r.profile = profile_q;
        r.level = level_q;
        r.set_id = id_q;
        r.frames_only = frame_only_q;
        expected_sizes.push_back(r);
        clear_walker();
    endfunction

    // ---- Unit builder ----
    function automatic void put_bits(longint unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) unit_bits.push_back(v[i]);
    endfunction

    function automatic void put_ue(longint unsigned v);
        longint unsigned x;
        int n;
        x = v + 1;
        n = 0;
        while ((x >> n) != 0) n++;
        put_bits(0, n - 1);
        put_bits(x, n);
    endfunction

    function automatic void put_se(int d);
        put_ue(d > 0 ? longint'(2 * d - 1) : longint'(-2 * d));
    endfunction

    // Closes the unit with a stop bit, optional trailing bytes, and may cut it short.
    function automatic void emit_unit(int cut_bytes);
        unit_byte_t ub;
        int nbytes;
        unit_bits.push_back(1'b1);
        while (unit_bits.size() % 8 != 0) unit_bits.push_back(1'b0);
        repeat ($urandom_range(0, 2)) put_bits($urandom_range(0, 255), 8);
        nbytes = unit_bits.size() / 8;
        if (cut_bytes > 0 && cut_bytes < nbytes) nbytes = cut_bytes;
        for (int i = 0; i < nbytes; i++) begin
            for (int j = 0; j < 8; j++) ub.data[7 - j] = unit_bits[8 * i + j];
            ub.last = (i == nbytes - 1);
            pending_bytes.push_back(ub);
        end
        unit_bits.delete();
    endfunction

    function automatic longint unsigned pick_small(int hi);
        return $urandom_range(0, 15) == 0 ? longint'($urandom) : longint'($urandom_range(0, hi));
    endfunction

    // Kinds of unit the builder makes.
    localparam int KIND_PLAIN     = 0;
    localparam int KIND_HIGH      = 1;
    localparam int KIND_POC_LIST  = 2;
    localparam int KIND_OVER_CROP = 3;
    localparam int KIND_HUGE      = 4;
    localparam int KIND_OVERLONG  = 5;
    localparam int KIND_TRUNCATED = 6;
    localparam int KIND_NOISE     = 7;

    function automatic void build_unit(int kind);
        logic [7:0] profile, prev, nx;
        int cnt, d, poc, ncycle;
        bit crop;
        if (kind == KIND_NOISE) begin
            repeat ($urandom_range(1, 12)) put_bits($urandom_range(0, 255), 8);
            emit_unit(0);
            return;
        end
        put_bits($urandom_range(0, 255), 8);
        case ($urandom_range(0, 7))
            0: profile = 8'd66;
            1: profile = 8'd77;
            2: profile = 8'd100;
            3: profile = 8'd110;
            4: profile = 8'd122;
            5: profile = 8'd144;
            6: profile = 8'd88;
            default: profile = $urandom_range(0, 255);
        endcase
        if (kind == KIND_HIGH) profile = 8'd100;
        put_bits(profile, 8);
        put_bits($urandom_range(0, 255), 8);
        put_bits($urandom_range(0, 255), 8);
        if (kind == KIND_OVERLONG && $urandom_range(0, 1)) put_bits(0, 33);
        else put_ue(pick_small(40));
        if (profile == 100 || profile == 110 || profile == 122 || profile == 144) begin
            d = $urandom_range(0, 4);
            put_ue(d);
            if (d == 3) put_bits($urandom_range(0, 1), 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits($urandom_range(0, 1), 1);
            if (kind == KIND_HIGH || $urandom_range(0, 1)) begin
                put_bits(1, 1);
                for (int l = 0; l < 8; l++) begin
                    if ($urandom_range(0, 2) == 0) begin put_bits(0, 1); continue; end
                    put_bits(1, 1);
                    prev = 8'd8;
                    cnt = (l < 6) ? 16 : 64;
                    for (int k = 0; k < cnt; k++) begin
                        d = $urandom_range(0, 20) == 0 ? -int'(prev) : $urandom_range(0, 16) - 8;
                        if ($urandom_range(0, 30) == 0) d = $urandom_range(0, 255) - 128;
                        put_se(d);
                        nx = prev + 8'(d);
                        if (nx == 0) break;
                        prev = nx;
                    end
                end
            end else begin
                put_bits(0, 1);
            end
        end
        put_ue($urandom_range(0, 12));
        poc = (kind == KIND_POC_LIST) ? 1 : $urandom_range(0, 4);
        put_ue(poc);
        if (poc == 0) put_ue($urandom_range(0, 12));
        else if (poc == 1) begin
            put_bits($urandom_range(0, 1), 1);
            put_se($urandom_range(0, 200) - 100);
            put_se($urandom_range(0, 200) - 100);
            ncycle = $urandom_range(0, 40) == 0 ? 300 : $urandom_range(0, 5);
            put_ue(ncycle);
            for (int k = 0; k < (ncycle > 255 ? 255 : ncycle); k++)
                put_se($urandom_range(0, 60) - 30);
        end
        put_ue($urandom_range(0, 16));
        put_bits($urandom_range(0, 1), 1);
        if (kind == KIND_HUGE) begin
            put_ue($urandom_range(0, 1) ? 70000 : $urandom_range(4095, 5000));
            put_ue($urandom_range(0, 1) ? longint'($urandom) : longint'($urandom_range(2000, 5000)));
        end else begin
            put_ue(pick_small(130));
            put_ue(pick_small(80));
        end
        d = $urandom_range(0, 1);
        put_bits(d, 1);
        if (d == 0) put_bits($urandom_range(0, 1), 1);
        put_bits($urandom_range(0, 1), 1);
        crop = (kind == KIND_OVER_CROP) || $urandom_range(0, 1);
        put_bits(crop, 1);
        if (crop) begin
            repeat (4) begin
                if (kind == KIND_OVER_CROP) put_ue($urandom_range(0, 1) ? 5000 : 150000);
                else put_ue(pick_small(8));
            end
        end
        emit_unit(kind == KIND_TRUNCATED ? $urandom_range(1, 10) : 0);
    endfunction

    // ---- Driver: one transfer per pending byte, random gaps between them ----
    int unsigned send_gap = 0;
    bit          send_burst = 1'b0;
    unit_byte_t  send_now;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_byte(send_now);
                if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 12);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    send_now = pending_bytes.pop_front();
                    s_tdata <= send_now.data;
                    s_tlast <= send_now.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---- Monitor: checks each result transfer, stalls m_tready at random ----
    int unsigned recv_stall = 0;
    bit          recv_burst = 1'b0;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        size_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sizes.size() == 0) begin
                    report_mismatch("unexpected result transfer", m_tdata[15:0], 0);
                end else begin
                    want = expected_sizes.pop_front();
                    if (m_tdata[15:0] !== want.width)
                        report_mismatch("pic_width", m_tdata[15:0], want.width);
                    if (m_tdata[31:16] !== want.height)
                        report_mismatch("pic_height", m_tdata[31:16], want.height);
                    if (m_tdata[39:32] !== want.profile)
                        report_mismatch("profile_code", m_tdata[39:32], want.profile);
                    if (m_tdata[47:40] !== want.level)
                        report_mismatch("level_code", m_tdata[47:40], want.level);
                    if (m_tdata[52:48] !== want.set_id)
                        report_mismatch("set_id", m_tdata[52:48], want.set_id);
                    if (m_tdata[53] !== want.frames_only)
                        report_mismatch("frames_only", m_tdata[53], want.frames_only);
                    if (m_tdata[55:54] !== want.status)
                        report_mismatch("parse_status", m_tdata[55:54], want.status);
                end
                if ($urandom_range(0, 8) == 0) recv_burst = ~recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 12);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---- Watchdog: ends the run if no transfer happens for too long ----
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---- Stimulus and end of run ----
    initial begin
        unit_byte_t single;
        clear_walker();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: header-only units, one of each kind, then another overlong and high unit.
        single.data = 8'hFF; single.last = 1'b1; pending_bytes.push_back(single);
        single.data = 8'h00; pending_bytes.push_back(single);
        for (int k = KIND_PLAIN; k <= KIND_NOISE; k++) build_unit(k);
        build_unit(KIND_OVERLONG);
        build_unit(KIND_HIGH);

        // Random: mostly well-formed units with random content.
        while (pending_bytes.size() < 1500) begin
            case ($urandom_range(0, 19))
                0: build_unit(KIND_NOISE);
                1: build_unit(KIND_TRUNCATED);
                2: build_unit(KIND_OVER_CROP);
                3: build_unit(KIND_HUGE);
                4: build_unit(KIND_OVERLONG);
                5, 6: build_unit(KIND_POC_LIST);
                7, 8, 9: build_unit(KIND_HIGH);
                default: build_unit(KIND_PLAIN);
            endcase
        end

        while (pending_bytes.size() > 0 || s_tvalid || expected_sizes.size() > 0)
            @(posedge aclk);
        // The last byte may still be in the walker; give the output register time.
        repeat (40) @(posedge aclk);
        if (error_count == 0 && expected_sizes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
